// File: sv/ocd_pkg.sv
// ----------------------------------------------------------------------------
// ocd_pkg
// Types and constants shared by the candle downsampler's controller, its
// datapath and its top level.
// ----------------------------------------------------------------------------
package ocd_pkg;

   // Fixed field widths of the channel words.
   localparam int PRICE_W  = 24;
   localparam int VOLUME_W = 24;
   localparam int TRADES_W = 16;
   localparam int COUNT_W  = 16;
   localparam int VOLSUM_W = 40;
   localparam int TRDSUM_W = 32;

   // One market bar on the request channel.
   typedef struct packed {
      logic                restart;
      logic [PRICE_W-1:0]  bar_open;
      logic [PRICE_W-1:0]  bar_high;
      logic [PRICE_W-1:0]  bar_low;
      logic [PRICE_W-1:0]  bar_close;
      logic [PRICE_W-1:0]  bar_wap;
      logic [VOLUME_W-1:0] bar_volume;
      logic [TRADES_W-1:0] bar_trades;
   } bar_word_type;

   // One merged candle on the response channel.
   typedef struct packed {
      logic [PRICE_W-1:0]  candle_open;
      logic [PRICE_W-1:0]  candle_high;
      logic [PRICE_W-1:0]  candle_low;
      logic [PRICE_W-1:0]  candle_close;
      logic [PRICE_W-1:0]  candle_vwap;
      logic [VOLSUM_W-1:0] candle_volume;
      logic [TRDSUM_W-1:0] candle_trades;
      logic                zero_volume;
   } candle_word_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } ocd_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_bar;
      logic clear;
      logic accum;
      logic start;
      logic div_step;
      logic emit;
   } ocd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic restart;
      logic complete;
      logic div_last;
      logic out_free;
   } ocd_status_type;

endpackage

// File: sv/ocd_ctrl.sv
// ----------------------------------------------------------------------------
// ocd_ctrl
// Controller of the candle downsampler: takes bars, sequences accumulation,
// the VWAP division and the hand-over of a finished candle.
// ----------------------------------------------------------------------------
module ocd_ctrl import ocd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ocd_status_type status,
   output ocd_cmd_type    cmd
);

   ocd_state_type state_ff;
   ocd_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (status.restart) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load_bar = 1'b1;
                  state_in     = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            if (status.complete) begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               cmd.accum = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/ocd_dpath.sv
// ----------------------------------------------------------------------------
// ocd_dpath
// Datapath of the candle downsampler: bar register and multiplier, running
// candle accumulators, restoring VWAP divider and the response register.
// ----------------------------------------------------------------------------
module ocd_dpath import ocd_pkg::*; #(
   parameter int PRICE_BITS  = 24,
   parameter int VOLUME_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  ocd_cmd_type         cmd,
   output ocd_status_type      status,
   input  bar_word_type        req_data,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output candle_word_type     rsp_data
);

   // Effective price and volume widths, and the derived sum widths.
   localparam int PW     = (PRICE_BITS > PRICE_W) ? PRICE_W : PRICE_BITS;
   localparam int VW     = VOLUME_BITS;
   localparam int PROD_W = PW + VW;
   localparam int WSUM_W = PW + VW + COUNT_W;
   localparam int CNT_W  = $clog2(PW);

   // Configuration register.
   logic [COUNT_W-1:0] bpc_ff;

   // Registered bar and its weighted price product.
   logic [PW-1:0]       bar_open_ff, bar_high_ff, bar_low_ff, bar_close_ff;
   logic [VW-1:0]       bar_vol_ff;
   logic [TRADES_W-1:0] bar_trades_ff;
   logic [PROD_W-1:0]   prod_ff;

   // Running candle accumulators.
   logic [COUNT_W-1:0]  seen_ff;
   logic [PW-1:0]       first_ff, high_ff, low_ff;
   logic [VOLSUM_W-1:0] vol_ff;
   logic [TRDSUM_W-1:0] trades_ff;
   logic [WSUM_W-1:0]   wsum_ff;

   logic [COUNT_W-1:0]  seen_in;
   logic [PW-1:0]       first_in, high_in, low_in;
   logic [VOLSUM_W-1:0] vol_in;
   logic [TRDSUM_W-1:0] trades_in;
   logic [WSUM_W-1:0]   wsum_in;
   logic [COUNT_W-1:0]  need;

   // Finished candle waiting for its VWAP.
   logic [PW-1:0]       cnd_open_ff, cnd_high_ff, cnd_low_ff, cnd_close_ff;
   logic [VOLSUM_W-1:0] cnd_vol_ff;
   logic [TRDSUM_W-1:0] cnd_trades_ff;

   // Divider.
   logic [VOLSUM_W-1:0] rem_ff, rem_in;
   logic [PW-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [VOLSUM_W:0]   rem_sh, trial;
   logic                zero_vol;

   // Response register.
   logic                rsp_valid_ff;
   candle_word_type     rsp_data_ff;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff <= COUNT_W'(1);
      end else if (csr_wr_en) begin
         bpc_ff <= csr_wr_data;
      end
   end

   // Capture a bar and form wap times volume.
   always_ff @(posedge clock) begin
      if (cmd.load_bar) begin
         bar_open_ff   <= req_data.bar_open[PW-1:0];
         bar_high_ff   <= req_data.bar_high[PW-1:0];
         bar_low_ff    <= req_data.bar_low[PW-1:0];
         bar_close_ff  <= req_data.bar_close[PW-1:0];
         bar_vol_ff    <= req_data.bar_volume[VW-1:0];
         bar_trades_ff <= req_data.bar_trades;
         prod_ff       <= PROD_W'(req_data.bar_wap[PW-1:0])
                          * PROD_W'(req_data.bar_volume[VW-1:0]);
      end
   end

   // Running values with the registered bar merged in.
   always_comb begin
      seen_in   = seen_ff + COUNT_W'(1);
      first_in  = (seen_ff == '0) ? bar_open_ff : first_ff;
      high_in   = (bar_high_ff > high_ff) ? bar_high_ff : high_ff;
      low_in    = (bar_low_ff < low_ff) ? bar_low_ff : low_ff;
      vol_in    = vol_ff + VOLSUM_W'(bar_vol_ff);
      trades_in = trades_ff + TRDSUM_W'(bar_trades_ff);
      wsum_in   = wsum_ff + WSUM_W'(prod_ff);
      need      = (bpc_ff == '0) ? COUNT_W'(1) : bpc_ff;
   end

   // Accumulators; reset, a restart or a finished candle returns them to empty.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear || cmd.start) begin
         seen_ff   <= '0;
         first_ff  <= '0;
         high_ff   <= '0;
         low_ff    <= '1;
         vol_ff    <= '0;
         trades_ff <= '0;
         wsum_ff   <= '0;
      end else if (cmd.accum) begin
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         vol_ff    <= vol_in;
         trades_ff <= trades_in;
         wsum_ff   <= wsum_in;
      end
   end

   // Hold the finished candle for the division and the hand-over.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cnd_open_ff   <= first_in;
         cnd_high_ff   <= high_in;
         cnd_low_ff    <= low_in;
         cnd_close_ff  <= bar_close_ff;
         cnd_vol_ff    <= vol_in;
         cnd_trades_ff <= trades_in;
      end
   end

   // One restoring step: shift in the next numerator bit and try a subtract.
   // The quotient never exceeds the largest price, so only the low PW
   // quotient bits are produced and the upper numerator bits seed the
   // remainder directly.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[PW-1]};
      trial  = rem_sh - {1'b0, cnd_vol_ff};
      if (!trial[VOLSUM_W]) begin
         rem_in = trial[VOLSUM_W-1:0];
         quo_in = {quo_ff[PW-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[VOLSUM_W-1:0];
         quo_in = {quo_ff[PW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= VOLSUM_W'(wsum_in >> PW);
         quo_ff <= wsum_in[PW-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign zero_vol = (cnd_vol_ff == '0);

   // Response register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.candle_open   <= PRICE_W'(cnd_open_ff);
         rsp_data_ff.candle_high   <= PRICE_W'(cnd_high_ff);
         rsp_data_ff.candle_low    <= PRICE_W'(cnd_low_ff);
         rsp_data_ff.candle_close  <= PRICE_W'(cnd_close_ff);
         rsp_data_ff.candle_vwap   <= zero_vol ? '0 : PRICE_W'(quo_ff);
         rsp_data_ff.candle_volume <= cnd_vol_ff;
         rsp_data_ff.candle_trades <= cnd_trades_ff;
         rsp_data_ff.zero_volume   <= zero_vol;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status to the controller.
   assign status.restart  = req_data.restart;
   assign status.complete = (seen_in == '0) || (seen_in >= need);
   assign status.div_last = (cnt_ff == CNT_W'(PW - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// File: sv/ohlcv_candle_downsampler.sv
// ----------------------------------------------------------------------------
// ohlcv_candle_downsampler
// Merges a configured number of consecutive market bars into one OHLCV
// candle with a volume-weighted average price.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one bar per word (req_valid / req_stall).
//   A word with restart set drops the partial candle.
//   Any other bar is first registered, with wap times volume formed, and
//   is then folded into the running candle.
//   When a bar completes its window, the candle's VWAP is found by a
//   restoring divider, one quotient bit a cycle, min(PRICE_BITS, 24) bits
//   (24 by default); the candle then moves to the response register once
//   that register is free. A completing bar holds the input until then.
//   The response channel (rsp_valid / rsp_stall) is fed from that register,
//   so bars keep being taken while a candle waits; if the next candle is
//   finished before the previous one is taken, the input stalls until the
//   response register frees.
//   csr_wr_en / csr_wr_data set the bars per candle (0 acts as 1); write it
//   only while the block is idle.
//   Synchronous reset empties the running candle, drops any pending
//   response and sets the bars per candle to one.
// ----------------------------------------------------------------------------
module ohlcv_candle_downsampler import ocd_pkg::*; #(
   parameter int PRICE_BITS  = 24,
   parameter int VOLUME_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bar_word_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output candle_word_type    rsp_data,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   ocd_cmd_type    cmd;
   ocd_status_type status;

   // Controller.
   ocd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   ocd_dpath #(
      .PRICE_BITS  (PRICE_BITS),
      .VOLUME_BITS (VOLUME_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // The controller issues at most one command a cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // A candle only enters the response register when that register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("candle written over an unread response");

   // While the divider runs no bar is taken.
   a_start_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("bar accepted during the VWAP division");

   // A handed-over candle is offered on the response channel.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted candle not presented");

endmodule

// File: dv/tb_ohlcv_candle_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ohlcv_candle_downsampler
// Drives market bars into the candle downsampler under random idling on
// both channels and checks each candle word against a predicted candle.
// A short directed part covers field extremes, zero volume, restart, the
// zero, mid-candle and largest window settings. Random phases follow, each
// at its own window setting, with one long window of near-full-scale bars.
// ----------------------------------------------------------------------------
module tb_ohlcv_candle_downsampler;
   import ocd_pkg::*;

   // Cycles allowed for words still in flight once every candle has come.
   localparam int SETTLE_CYCLES  = 40;
   // Cycles without any handshake before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   bar_word_type       req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   candle_word_type    rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   // Predicted window state and the window setting.
   logic [COUNT_W-1:0]  bars_setting;
   logic [COUNT_W-1:0]  win_count;
   logic [PRICE_W-1:0]  win_open;
   logic [PRICE_W-1:0]  win_high;
   logic [PRICE_W-1:0]  win_low;
   logic [VOLSUM_W-1:0] win_volume;
   logic [TRDSUM_W-1:0] win_trades;
   logic [63:0]         win_weighted;

   candle_word_type pending_candles[$];
   int  fail_count  = 0;
   bit  gaps_on     = 1'b1;
   bit  stalls_on   = 1'b1;
   int  stall_hold  = 0;
   int  idle_cycles = 0;

   ohlcv_candle_downsampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Empties the running window, as after reset or a finished candle.
   function automatic void clear_window();
      win_count    = '0;
      win_open     = '0;
      win_high     = '0;
      win_low      = '1;
      win_volume   = '0;
      win_trades   = '0;
      win_weighted = '0;
   endfunction

   // Folds one accepted bar word into the window and queues the candle
   // that it completes, if any.
   function automatic void fold_bar(input bar_word_type b);
      candle_word_type c;
      logic [COUNT_W-1:0] need;
      if (b.restart) begin
         clear_window();
         return;
      end
      if (win_count == 0) win_open = b.bar_open;
      if (b.bar_high > win_high) win_high = b.bar_high;
      if (b.bar_low < win_low) win_low = b.bar_low;
      win_volume   = win_volume + VOLSUM_W'(b.bar_volume);
      win_trades   = win_trades + TRDSUM_W'(b.bar_trades);
      win_weighted = win_weighted + 64'(b.bar_wap) * 64'(b.bar_volume);
      win_count    = win_count + 1'b1;
      // A setting of zero behaves as one.
      need = (bars_setting == 0) ? COUNT_W'(1) : bars_setting;
      if (win_count != 0 && win_count < need) return;
      c.candle_open   = win_open;
      c.candle_high   = win_high;
      c.candle_low    = win_low;
      c.candle_close  = b.bar_close;
      c.candle_volume = win_volume;
      c.candle_trades = win_trades;
      if (win_volume == 0) begin
         c.candle_vwap = '0;
         c.zero_volume = 1'b1;
      end else begin
         c.candle_vwap = PRICE_W'(win_weighted / 64'(win_volume));
         c.zero_volume = 1'b0;
      end
      pending_candles = {pending_candles, c};
      clear_window();
   endfunction

   function automatic logic [PRICE_W-1:0] pick_price(input bit near_top);
      int r;
      if (near_top) return PRICE_W'($urandom_range(24'hF00000, 24'hFFFFFF));
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      return PRICE_W'($urandom);
   endfunction

   function automatic bar_word_type random_bar(input int restart_pct, input int zero_vol_pct,
                                               input bit near_top);
      bar_word_type b;
      int r;
      b.restart    = ($urandom_range(0, 99) < restart_pct);
      b.bar_open   = pick_price(near_top);
      b.bar_high   = pick_price(near_top);
      b.bar_low    = pick_price(near_top);
      b.bar_close  = pick_price(near_top);
      b.bar_wap    = pick_price(near_top);
      b.bar_volume = ($urandom_range(0, 99) < zero_vol_pct) ? '0 : pick_price(near_top);
      r = $urandom_range(0, 99);
      if (near_top) b.bar_trades = TRADES_W'($urandom_range(16'hF000, 16'hFFFF));
      else if (r < 8) b.bar_trades = '0;
      else if (r < 16) b.bar_trades = '1;
      else b.bar_trades = TRADES_W'($urandom);
      return b;
   endfunction

   function automatic bar_word_type make_bar(input logic [23:0] open_p, high_p, low_p,
                                             close_p, wap_p, vol,
                                             input logic [15:0] trades);
      bar_word_type b;
      b.restart    = 1'b0;
      b.bar_open   = open_p;
      b.bar_high   = high_p;
      b.bar_low    = low_p;
      b.bar_close  = close_p;
      b.bar_wap    = wap_p;
      b.bar_volume = vol;
      b.bar_trades = trades;
      return b;
   endfunction

   // Offers one bar word after an optional gap and waits for its acceptance.
   task automatic send_bar(input bar_word_type b);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      fold_bar(b);
   endtask

   // Holds the sender back until every predicted candle has arrived, then
   // lets words still in the pipeline settle.
   task automatic hold_until_drained(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_candles.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Writes the window setting while the block is idle.
   task automatic write_setting(input logic [COUNT_W-1:0] value);
      hold_until_drained(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bars_setting = value;
   endtask

   // Single-bar candles at the field extremes, zero volume among them.
   task automatic test_field_extremes();
      write_setting(16'd1);
      send_bar(make_bar('1, '1, '1, '1, '1, '1, '1));
      send_bar(make_bar('0, '0, '0, '0, '0, '0, '0));
      send_bar(make_bar('0, '1, '0, '1, 24'h123456, 24'd1, 16'd1));
      send_bar(make_bar(24'hABCDEF, 24'h000001, '1, '0, '1, '0, 16'h8000));
   endtask

   // A setting of zero gives one candle per bar.
   task automatic test_zero_setting();
      write_setting(16'd0);
      send_bar(random_bar(0, 0, 1'b0));
      send_bar(random_bar(0, 0, 1'b0));
   endtask

   // A restart word drops the partial candle, whatever its bar fields hold.
   task automatic test_restart();
      bar_word_type junk;
      junk = '1;
      write_setting(16'd3);
      send_bar(random_bar(0, 0, 1'b0));
      send_bar(random_bar(0, 0, 1'b0));
      send_bar(junk);
      send_bar(random_bar(0, 0, 1'b0));
      send_bar(random_bar(0, 0, 1'b0));
      send_bar(random_bar(0, 0, 1'b0));
   endtask

   // Lowering the setting below the bars already taken ends the candle on
   // the next bar.
   task automatic test_mid_candle_change();
      write_setting(16'd5);
      repeat (3) send_bar(random_bar(0, 0, 1'b0));
      write_setting(16'd2);
      send_bar(random_bar(0, 0, 1'b0));
   endtask

   // The largest setting, left by a restart before it could complete.
   task automatic test_largest_setting();
      bar_word_type b;
      write_setting(16'hFFFF);
      repeat (3) send_bar(random_bar(0, 10, 1'b0));
      b = random_bar(0, 0, 1'b0);
      b.restart = 1'b1;
      send_bar(b);
   endtask

   task automatic run_random_phase(input logic [COUNT_W-1:0] setting, input int count,
                                   input int restart_pct, input int zero_vol_pct,
                                   input bit near_top, input bit pause_midway);
      write_setting(setting);
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) hold_until_drained(0);
         send_bar(random_bar(restart_pct, zero_vol_pct, near_top));
      end
   endtask

   // Random phases at several settings and idling patterns.
   task automatic test_random_windows();
      gaps_on = 1'b1; stalls_on = 1'b1;
      run_random_phase(16'd1, 80, 5, 10, 1'b0, 1'b0);
      // No idling on either side.
      gaps_on = 1'b0; stalls_on = 1'b0;
      run_random_phase(16'd2, 80, 5, 10, 1'b0, 1'b0);
      gaps_on = 1'b1; stalls_on = 1'b1;
      run_random_phase(16'd3, 80, 8, 5, 1'b0, 1'b1);
      // Back-to-back bars against a stalling receiver.
      gaps_on = 1'b0; stalls_on = 1'b1;
      run_random_phase(16'd4, 80, 5, 30, 1'b0, 1'b0);
      gaps_on = 1'b1;
      run_random_phase(16'd0, 60, 10, 20, 1'b0, 1'b0);
      run_random_phase(16'd7, 80, 5, 10, 1'b0, 1'b0);
      run_random_phase(COUNT_W'($urandom_range(5, 16)), 90, 5, 10, 1'b0, 1'b0);
      // A long window of near-full-scale bars carries the volume sum past
      // 32 bits.
      gaps_on = 1'b0;
      run_random_phase(16'd400, 400, 0, 0, 1'b1, 1'b0);
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      if (reset || !stalls_on) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_hold = pick_gap();
      end
   end

   task automatic report_field(input string name, input logic [39:0] want, got);
      if (want !== got) begin
         $display("%0t: candle %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Compares each accepted candle word with the oldest predicted candle.
   always @(posedge clock) begin : check_candles
      candle_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_candles.size() == 0) begin
            $display("%0t: unexpected candle, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_candles.pop_front();
            report_field("open", want.candle_open, rsp_data.candle_open);
            report_field("high", want.candle_high, rsp_data.candle_high);
            report_field("low", want.candle_low, rsp_data.candle_low);
            report_field("close", want.candle_close, rsp_data.candle_close);
            report_field("vwap", want.candle_vwap, rsp_data.candle_vwap);
            report_field("volume", want.candle_volume, rsp_data.candle_volume);
            report_field("trades", want.candle_trades, rsp_data.candle_trades);
            report_field("zero_volume", want.zero_volume, rsp_data.zero_volume);
         end
      end
   end

   // Ends the run when no handshake has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      bars_setting = COUNT_W'(1);
      clear_window();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_zero_setting();
      test_restart();
      test_mid_candle_change();
      test_largest_setting();
      test_random_windows();

      hold_until_drained(SETTLE_CYCLES);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
